>>> rtl/rce_pkg.sv
package rce_pkg;

    localparam int SYM_W     = 8;
    localparam int OP_W      = 3;
    localparam int RIDX_W    = 3;
    localparam int ALPHA_W   = 9;
    localparam int RCOUNT_W  = 4;
    localparam int TBL_DEPTH = 256;
    localparam int CHAR_W    = 32;
    localparam int STEP_W    = 6;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_PLUG  = 3'd0,
        OP_LOAD_REFL  = 3'd1,
        OP_LOAD_ROTOR = 3'd2,
        OP_ENCODE     = 3'd3,
        OP_START      = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_PLUG_DATA,
        RD_PLUG_CODE,
        RD_REFL_CODE,
        RD_ROTOR
    } rd_sel_t;

    typedef enum logic [2:0] {
        CODE_HOLD,
        CODE_PLUG,
        CODE_REFL,
        CODE_ROTOR,
        CODE_POS,
        CODE_ZERO
    } code_sel_t;

    typedef enum logic [1:0] {
        MS_OFFSET,
        MS_CODE,
        MS_ENTRY,
        MS_COUNTER
    } mod_src_t;

    typedef enum logic [2:0] {
        J_HOLD,
        J_ZERO,
        J_ONE,
        J_INC,
        J_DEC,
        J_LAST,
        J_RIDX
    } j_op_t;

    typedef enum logic [1:0] {
        POS_HOLD,
        POS_REM,
        POS_CLR,
        POS_INC
    } pos_op_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [RIDX_W-1:0] rotor_index;
        logic [SYM_W-1:0]  entry_index;
        logic [SYM_W-1:0]  entry_value;
        logic [SYM_W-1:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic      latch;
        logic      wr_plug;
        logic      wr_refl;
        logic      wr_rotor;
        rd_sel_t   rd;
        code_sel_t code_ld;
        logic      mod_start;
        mod_src_t  mod_src;
        logic      k_ld;
        pos_op_t   pos_op;
        j_op_t     j_op;
        logic      fail_clr;
        logic      fail_set;
        logic      off_inc;
        logic      cnt_one;
        logic      cnt_inc;
        logic      push;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            ridx_ok;
        logic            mod_done;
        logic            rem_zero;
        logic            hit;
        logic            scan_last;
        logic            j_last_fwd;
        logic            j_lt_n;
        logic            j_zero;
        logic            out_full;
    } stat_t;

endpackage

>>> rtl/rce_if.sv
interface rce_in_if;
    logic                         valid;
    logic                         ready;
    logic [rce_pkg::OP_W-1:0]     op;
    logic [rce_pkg::RIDX_W-1:0]   rotor_index;
    logic [rce_pkg::SYM_W-1:0]    entry_index;
    logic [rce_pkg::SYM_W-1:0]    entry_value;
    logic [rce_pkg::SYM_W-1:0]    data_byte;

    modport source (output valid, op, rotor_index, entry_index, entry_value, data_byte,
                    input ready);
    modport sink (input valid, op, rotor_index, entry_index, entry_value, data_byte,
                  output ready);
endinterface

interface rce_out_if;
    logic                      valid;
    logic                      ready;
    logic [rce_pkg::SYM_W-1:0] code_out;
    logic                      lookup_failed;

    modport source (output valid, code_out, lookup_failed, input ready);
    modport sink (input valid, code_out, lookup_failed, output ready);
endinterface

>>> rtl/rce_ram.sv
module rce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/rce_mod.sv
// Restoring remainder unit, one dividend bit per cycle.
module rce_mod #(
    parameter int DIV_W = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [rce_pkg::CHAR_W-1:0]   dividend,
    input  logic [DIV_W-1:0]             divisor,
    input  logic [rce_pkg::STEP_W-1:0]   steps,
    output logic [DIV_W-1:0]             rem,
    output logic                         done
);

    logic                         busy_reg;
    logic [rce_pkg::STEP_W-1:0]   cnt_reg;
    logic [rce_pkg::CHAR_W-1:0]   quo_reg;
    logic [DIV_W-1:0]             rem_reg;
    logic [DIV_W-1:0]             div_reg;
    logic [DIV_W:0]               trial;
    logic [DIV_W-1:0]             rem_next;

    always_comb
    begin
        trial = {rem_reg, quo_reg[rce_pkg::CHAR_W-1]};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = DIV_W'(trial - {1'b0, div_reg});
        end
        else
        begin
            rem_next = trial[DIV_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= steps;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[rce_pkg::CHAR_W-2:0], 1'b0};
        end
    end

    assign rem  = rem_reg;
    assign done = busy_reg && (cnt_reg == '0);

endmodule

>>> rtl/rce_dp.sv
module rce_dp #(
    parameter int MAX_ALPHABET = 256,
    parameter int MAX_ROTORS   = 8,
    localparam int CNT_W = $clog2(MAX_ROTORS + 1),
    localparam int RIX_W = (MAX_ROTORS > 1) ? $clog2(MAX_ROTORS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [rce_pkg::ALPHA_W-1:0]   a_eff,
    input  logic [CNT_W-1:0]              n_eff,
    input  rce_pkg::item_t                item,
    input  rce_pkg::cmd_t                 cmd,
    output rce_pkg::stat_t                stat,
    output logic [rce_pkg::SYM_W-1:0]     code_out,
    output logic                          lookup_failed,
    output logic                          out_valid,
    input  logic                          out_ready
);

    localparam int RA_W   = $clog2(MAX_ROTORS * MAX_ALPHABET);
    localparam int PROD_W = $clog2(MAX_ALPHABET * MAX_ROTORS + 1);
    localparam int DIV_W  = (PROD_W > rce_pkg::ALPHA_W) ? PROD_W : rce_pkg::ALPHA_W;

    rce_pkg::item_t             f_reg;
    logic [rce_pkg::SYM_W-1:0]  code_reg;
    logic [rce_pkg::SYM_W-1:0]  pos_reg;
    logic [rce_pkg::SYM_W-1:0]  k_reg;
    logic [CNT_W-1:0]           j_reg;
    logic                       fail_reg;
    logic [rce_pkg::CHAR_W-1:0] cnt_reg;
    logic [rce_pkg::SYM_W-1:0]  off_reg [MAX_ROTORS];
    logic [rce_pkg::SYM_W-1:0]  out_code_reg;
    logic                       out_fail_reg;
    logic                       out_valid_reg;

    logic [RIX_W-1:0]           jx;
    logic [9:0]                 phys_sum;
    logic [rce_pkg::SYM_W-1:0]  phys;
    logic [RA_W-1:0]            rot_addr;
    logic [rce_pkg::SYM_W-1:0]  plug_rdata;
    logic [rce_pkg::SYM_W-1:0]  refl_rdata;
    logic [rce_pkg::SYM_W-1:0]  rot_rdata;
    logic [rce_pkg::SYM_W-1:0]  plug_raddr;
    logic [rce_pkg::CHAR_W-1:0] mod_dividend;
    logic [DIV_W-1:0]           mod_divisor;
    logic [rce_pkg::STEP_W-1:0] mod_steps;
    logic [DIV_W-1:0]           mod_rem;
    logic                       mod_done;
    logic [rce_pkg::ALPHA_W-1:0] off_inc9;
    logic [rce_pkg::SYM_W-1:0]  off_next;
    logic [rce_pkg::SYM_W-1:0]  code_next;

    assign jx = j_reg[RIX_W-1:0];

    // Physical slot of logical position pos on a rotor turned k times.
    always_comb
    begin
        phys_sum = {2'b00, pos_reg} + {1'b0, a_eff} - {2'b00, k_reg};
        if (phys_sum >= {1'b0, a_eff})
        begin
            phys = rce_pkg::SYM_W'(phys_sum - {1'b0, a_eff});
        end
        else
        begin
            phys = phys_sum[rce_pkg::SYM_W-1:0];
        end
        rot_addr = RA_W'(32'(jx) * MAX_ALPHABET + 32'(phys));
    end

    assign plug_raddr = (cmd.rd == rce_pkg::RD_PLUG_DATA) ? f_reg.data_byte : code_reg;

    rce_ram #(.WIDTH(rce_pkg::SYM_W), .DEPTH(rce_pkg::TBL_DEPTH)) u_plug (
        .clk   (clk),
        .we    (cmd.wr_plug),
        .waddr (f_reg.entry_index),
        .wdata (f_reg.entry_value),
        .re    (cmd.rd == rce_pkg::RD_PLUG_DATA || cmd.rd == rce_pkg::RD_PLUG_CODE),
        .raddr (plug_raddr),
        .rdata (plug_rdata)
    );

    rce_ram #(.WIDTH(rce_pkg::SYM_W), .DEPTH(rce_pkg::TBL_DEPTH)) u_refl (
        .clk   (clk),
        .we    (cmd.wr_refl),
        .waddr (f_reg.entry_index),
        .wdata (f_reg.entry_value),
        .re    (cmd.rd == rce_pkg::RD_REFL_CODE),
        .raddr (code_reg),
        .rdata (refl_rdata)
    );

    rce_ram #(.WIDTH(rce_pkg::SYM_W), .DEPTH(MAX_ROTORS * MAX_ALPHABET)) u_rotor (
        .clk   (clk),
        .we    (cmd.wr_rotor),
        .waddr (rot_addr),
        .wdata (f_reg.entry_value),
        .re    (cmd.rd == rce_pkg::RD_ROTOR),
        .raddr (rot_addr),
        .rdata (rot_rdata)
    );

    always_comb
    begin
        mod_divisor  = DIV_W'(a_eff);
        mod_steps    = rce_pkg::STEP_W'(rce_pkg::SYM_W);
        mod_dividend = {off_reg[jx], 24'd0};
        unique case (cmd.mod_src)
            rce_pkg::MS_OFFSET:
            begin
                mod_dividend = {off_reg[jx], 24'd0};
            end
            rce_pkg::MS_CODE:
            begin
                mod_dividend = {code_reg, 24'd0};
            end
            rce_pkg::MS_ENTRY:
            begin
                mod_dividend = {f_reg.entry_index, 24'd0};
            end
            rce_pkg::MS_COUNTER:
            begin
                mod_dividend = cnt_reg;
                mod_divisor  = DIV_W'(32'(a_eff) * 32'(j_reg));
                mod_steps    = rce_pkg::STEP_W'(rce_pkg::CHAR_W);
            end
            default:
            begin
                mod_dividend = {off_reg[jx], 24'd0};
            end
        endcase
    end

    rce_mod #(.DIV_W(DIV_W)) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.mod_start),
        .dividend (mod_dividend),
        .divisor  (mod_divisor),
        .steps    (mod_steps),
        .rem      (mod_rem),
        .done     (mod_done)
    );

    always_comb
    begin
        off_inc9 = {1'b0, mod_rem[rce_pkg::SYM_W-1:0]} + 9'd1;
        off_next = (off_inc9 == a_eff) ? '0 : off_inc9[rce_pkg::SYM_W-1:0];
        unique case (cmd.code_ld)
            rce_pkg::CODE_HOLD:  code_next = code_reg;
            rce_pkg::CODE_PLUG:  code_next = plug_rdata;
            rce_pkg::CODE_REFL:  code_next = refl_rdata;
            rce_pkg::CODE_ROTOR: code_next = rot_rdata;
            rce_pkg::CODE_POS:   code_next = pos_reg;
            rce_pkg::CODE_ZERO:  code_next = '0;
            default:             code_next = code_reg;
        endcase
    end

    // Working registers carry payload only.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            f_reg <= item;
        end
        code_reg <= code_next;
        if (cmd.k_ld)
        begin
            k_reg <= mod_rem[rce_pkg::SYM_W-1:0];
        end
        unique case (cmd.pos_op)
            rce_pkg::POS_HOLD: pos_reg <= pos_reg;
            rce_pkg::POS_REM:  pos_reg <= mod_rem[rce_pkg::SYM_W-1:0];
            rce_pkg::POS_CLR:  pos_reg <= '0;
            rce_pkg::POS_INC:  pos_reg <= pos_reg + 1'b1;
            default:           pos_reg <= pos_reg;
        endcase
        unique case (cmd.j_op)
            rce_pkg::J_HOLD: j_reg <= j_reg;
            rce_pkg::J_ZERO: j_reg <= '0;
            rce_pkg::J_ONE:  j_reg <= CNT_W'(1);
            rce_pkg::J_INC:  j_reg <= j_reg + 1'b1;
            rce_pkg::J_DEC:  j_reg <= j_reg - 1'b1;
            rce_pkg::J_LAST: j_reg <= n_eff - 1'b1;
            rce_pkg::J_RIDX: j_reg <= CNT_W'(f_reg.rotor_index);
            default:         j_reg <= j_reg;
        endcase
        if (cmd.fail_clr)
        begin
            fail_reg <= 1'b0;
        end
        else if (cmd.fail_set)
        begin
            fail_reg <= 1'b1;
        end
        if (cmd.push)
        begin
            out_code_reg <= plug_rdata;
            out_fail_reg <= fail_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= rce_pkg::CHAR_W'(1);
            out_valid_reg <= 1'b0;
            for (int r = 0; r < MAX_ROTORS; r++)
            begin
                off_reg[r] <= '0;
            end
        end
        else
        begin
            if (cmd.cnt_one)
            begin
                cnt_reg <= rce_pkg::CHAR_W'(1);
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.off_inc)
            begin
                off_reg[jx] <= off_next;
            end
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.op         = f_reg.op;
        stat.ridx_ok    = 32'(f_reg.rotor_index) < MAX_ROTORS;
        stat.mod_done   = mod_done;
        stat.rem_zero   = (mod_rem == '0);
        stat.hit        = (rot_rdata == code_reg);
        stat.scan_last  = (({1'b0, pos_reg} + 9'd1) == a_eff);
        stat.j_last_fwd = ((j_reg + CNT_W'(1)) == n_eff);
        stat.j_lt_n     = (j_reg < n_eff);
        stat.j_zero     = (j_reg == '0);
        stat.out_full   = out_valid_reg;
    end

    assign code_out      = out_code_reg;
    assign lookup_failed = out_fail_reg;
    assign out_valid     = out_valid_reg;

endmodule

>>> rtl/rce_ctrl.sv
module rce_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rce_pkg::stat_t stat,
    output rce_pkg::cmd_t  cmd
);

    typedef enum logic [24:0] {
        S_IDLE  = 25'd1 << 0,
        S_DISP  = 25'd1 << 1,
        S_LK    = 25'd1 << 2,
        S_LK_W  = 25'd1 << 3,
        S_LP_W  = 25'd1 << 4,
        S_L_WR  = 25'd1 << 5,
        S_PL_W  = 25'd1 << 6,
        S_FK    = 25'd1 << 7,
        S_FK_W  = 25'd1 << 8,
        S_FP_W  = 25'd1 << 9,
        S_F_RD  = 25'd1 << 10,
        S_F_W   = 25'd1 << 11,
        S_R_RD  = 25'd1 << 12,
        S_R_W   = 25'd1 << 13,
        S_BK    = 25'd1 << 14,
        S_BK_W  = 25'd1 << 15,
        S_B_RD  = 25'd1 << 16,
        S_B_CMP = 25'd1 << 17,
        S_P2_RD = 25'd1 << 18,
        S_P2_W  = 25'd1 << 19,
        S_T0    = 25'd1 << 20,
        S_T0_W  = 25'd1 << 21,
        S_TC    = 25'd1 << 22,
        S_TC_W  = 25'd1 << 23,
        S_TK_W  = 25'd1 << 24
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   next_rotor_back;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd             = '0;
        cmd.rd          = rce_pkg::RD_NONE;
        cmd.code_ld     = rce_pkg::CODE_HOLD;
        cmd.mod_src     = rce_pkg::MS_OFFSET;
        cmd.pos_op      = rce_pkg::POS_HOLD;
        cmd.j_op        = rce_pkg::J_HOLD;
        in_ready        = 1'b0;
        next_rotor_back = 1'b0;
        state_next      = state_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
                if (in_valid)
                begin
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                state_next = S_IDLE;
                unique case (stat.op)
                    rce_pkg::OP_LOAD_PLUG:  cmd.wr_plug = 1'b1;
                    rce_pkg::OP_LOAD_REFL:  cmd.wr_refl = 1'b1;
                    rce_pkg::OP_START:      cmd.cnt_one = 1'b1;
                    rce_pkg::OP_LOAD_ROTOR:
                    begin
                        if (stat.ridx_ok)
                        begin
                            cmd.j_op   = rce_pkg::J_RIDX;
                            state_next = S_LK;
                        end
                    end
                    rce_pkg::OP_ENCODE:
                    begin
                        cmd.rd       = rce_pkg::RD_PLUG_DATA;
                        cmd.fail_clr = 1'b1;
                        cmd.j_op     = rce_pkg::J_ZERO;
                        state_next   = S_PL_W;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            // Rotor load: reduce the turn count and the position, then write.
            S_LK:
            begin
                cmd.mod_start = 1'b1;
                cmd.mod_src   = rce_pkg::MS_OFFSET;
                state_next    = S_LK_W;
            end
            S_LK_W:
            begin
                if (stat.mod_done)
                begin
                    cmd.k_ld      = 1'b1;
                    cmd.mod_start = 1'b1;
                    cmd.mod_src   = rce_pkg::MS_ENTRY;
                    state_next    = S_LP_W;
                end
            end
            S_LP_W:
            begin
                if (stat.mod_done)
                begin
                    cmd.pos_op = rce_pkg::POS_REM;
                    state_next = S_L_WR;
                end
            end
            S_L_WR:
            begin
                cmd.wr_rotor = 1'b1;
                state_next   = S_IDLE;
            end
            // Forward pass.
            S_PL_W:
            begin
                cmd.code_ld = rce_pkg::CODE_PLUG;
                state_next  = S_FK;
            end
            S_FK:
            begin
                cmd.mod_start = 1'b1;
                cmd.mod_src   = rce_pkg::MS_OFFSET;
                state_next    = S_FK_W;
            end
            S_FK_W:
            begin
                if (stat.mod_done)
                begin
                    cmd.k_ld      = 1'b1;
                    cmd.mod_start = 1'b1;
                    cmd.mod_src   = rce_pkg::MS_CODE;
                    state_next    = S_FP_W;
                end
            end
            S_FP_W:
            begin
                if (stat.mod_done)
                begin
                    cmd.pos_op = rce_pkg::POS_REM;
                    state_next = S_F_RD;
                end
            end
            S_F_RD:
            begin
                cmd.rd     = rce_pkg::RD_ROTOR;
                state_next = S_F_W;
            end
            S_F_W:
            begin
                cmd.code_ld = rce_pkg::CODE_ROTOR;
                if (stat.j_last_fwd)
                begin
                    state_next = S_R_RD;
                end
                else
                begin
                    cmd.j_op   = rce_pkg::J_INC;
                    state_next = S_FK;
                end
            end
            S_R_RD:
            begin
                cmd.rd     = rce_pkg::RD_REFL_CODE;
                cmd.j_op   = rce_pkg::J_LAST;
                state_next = S_R_W;
            end
            S_R_W:
            begin
                cmd.code_ld = rce_pkg::CODE_REFL;
                state_next  = S_BK;
            end
            // Backward pass: scan logical positions from zero for the first match.
            S_BK:
            begin
                cmd.mod_start = 1'b1;
                cmd.mod_src   = rce_pkg::MS_OFFSET;
                state_next    = S_BK_W;
            end
            S_BK_W:
            begin
                if (stat.mod_done)
                begin
                    cmd.k_ld   = 1'b1;
                    cmd.pos_op = rce_pkg::POS_CLR;
                    state_next = S_B_RD;
                end
            end
            S_B_RD:
            begin
                cmd.rd     = rce_pkg::RD_ROTOR;
                state_next = S_B_CMP;
            end
            S_B_CMP:
            begin
                if (stat.hit)
                begin
                    cmd.code_ld     = rce_pkg::CODE_POS;
                    next_rotor_back = 1'b1;
                end
                else if (stat.scan_last)
                begin
                    cmd.code_ld     = rce_pkg::CODE_ZERO;
                    cmd.fail_set    = 1'b1;
                    next_rotor_back = 1'b1;
                end
                else
                begin
                    cmd.pos_op = rce_pkg::POS_INC;
                    state_next = S_B_RD;
                end
                if (next_rotor_back)
                begin
                    if (stat.j_zero)
                    begin
                        state_next = S_P2_RD;
                    end
                    else
                    begin
                        cmd.j_op   = rce_pkg::J_DEC;
                        state_next = S_BK;
                    end
                end
            end
            S_P2_RD:
            begin
                cmd.rd     = rce_pkg::RD_PLUG_CODE;
                state_next = S_P2_W;
            end
            S_P2_W:
            begin
                if (!stat.out_full)
                begin
                    cmd.push   = 1'b1;
                    cmd.j_op   = rce_pkg::J_ZERO;
                    state_next = S_T0;
                end
            end
            // Stepping: rotor 0 always, rotor j on counter multiples of a*j.
            S_T0:
            begin
                cmd.mod_start = 1'b1;
                cmd.mod_src   = rce_pkg::MS_OFFSET;
                state_next    = S_T0_W;
            end
            S_T0_W:
            begin
                if (stat.mod_done)
                begin
                    cmd.off_inc = 1'b1;
                    cmd.j_op    = rce_pkg::J_ONE;
                    state_next  = S_TC;
                end
            end
            S_TC:
            begin
                if (stat.j_lt_n)
                begin
                    cmd.mod_start = 1'b1;
                    cmd.mod_src   = rce_pkg::MS_COUNTER;
                    state_next    = S_TC_W;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_TC_W:
            begin
                if (stat.mod_done)
                begin
                    if (stat.rem_zero)
                    begin
                        cmd.mod_start = 1'b1;
                        cmd.mod_src   = rce_pkg::MS_OFFSET;
                        state_next    = S_TK_W;
                    end
                    else
                    begin
                        cmd.j_op   = rce_pkg::J_INC;
                        state_next = S_TC;
                    end
                end
            end
            S_TK_W:
            begin
                if (stat.mod_done)
                begin
                    cmd.off_inc = 1'b1;
                    cmd.j_op    = rce_pkg::J_INC;
                    state_next  = S_TC;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/rotor_cipher_byte_engine.sv
// Byte-wise rotor cipher engine. Items arrive one at a time on in_ch: loads fill the
// plugboard, reflector and rotor tables (rotor loads land at the given position of the
// rotor as it is turned now), a start item resets the character counter to one, and an
// encode item returns one transfer on out_ch carrying the coded byte and a flag that is
// set when some backward rotor lookup found no matching entry (the code then goes on as
// zero). The engine works on one item at a time; a finished result waits in an output
// register, so the next item is taken while it is still pending. The time of an encode
// grows with the rotor count, with the rotor entries scanned in the backward pass (the
// first matching logical position, up to alphabet_size) and with each rotor above
// rotor 0 that turns. It is set by a shared one-bit-a-cycle remainder unit, which
// reduces turn counts and positions modulo alphabet_size and tests the counter against
// alphabet_size*j, and by the single read port of the rotor table memory used for the
// backward scan. alphabet_size and rotor_count sit at byte addresses 0 and 4 of the APB
// port; write them only while the engine is idle. Out-of-range values act as the
// nearest legal value. Table memories need no clearing pass after reset; contents are
// undefined until loaded.
module rotor_cipher_byte_engine #(
    parameter int MAX_ALPHABET = 256,
    parameter int MAX_ROTORS   = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    rce_in_if.sink           in_ch,
    rce_out_if.source        out_ch,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int CNT_W = $clog2(MAX_ROTORS + 1);

    logic [rce_pkg::ALPHA_W-1:0]  alpha_reg;
    logic [rce_pkg::RCOUNT_W-1:0] rcount_reg;
    logic [rce_pkg::ALPHA_W-1:0]  a_eff;
    logic [CNT_W-1:0]             n_eff;
    logic                         cfg_wr;
    rce_pkg::item_t               item;
    rce_pkg::cmd_t                cmd;
    rce_pkg::stat_t               stat;

    // Register file: bit 2 of paddr selects the register.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg  <= rce_pkg::ALPHA_W'(256);
            rcount_reg <= rce_pkg::RCOUNT_W'(3);
        end
        else if (cfg_wr)
        begin
            if (paddr[2])
            begin
                rcount_reg <= pwdata[rce_pkg::RCOUNT_W-1:0];
            end
            else
            begin
                alpha_reg <= pwdata[rce_pkg::ALPHA_W-1:0];
            end
        end
    end

    assign prdata = paddr[2] ? {28'd0, rcount_reg} : {23'd0, alpha_reg};

    // Clamp the registers to the range the hardware was built for.
    always_comb
    begin
        if (alpha_reg == '0)
        begin
            a_eff = rce_pkg::ALPHA_W'(1);
        end
        else if (32'(alpha_reg) > MAX_ALPHABET)
        begin
            a_eff = rce_pkg::ALPHA_W'(MAX_ALPHABET);
        end
        else
        begin
            a_eff = alpha_reg;
        end
        if (rcount_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (32'(rcount_reg) > MAX_ROTORS)
        begin
            n_eff = CNT_W'(MAX_ROTORS);
        end
        else
        begin
            n_eff = CNT_W'(rcount_reg);
        end
    end

    assign item.op          = in_ch.op;
    assign item.rotor_index = in_ch.rotor_index;
    assign item.entry_index = in_ch.entry_index;
    assign item.entry_value = in_ch.entry_value;
    assign item.data_byte   = in_ch.data_byte;

    rce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rce_dp #(.MAX_ALPHABET(MAX_ALPHABET), .MAX_ROTORS(MAX_ROTORS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .a_eff         (a_eff),
        .n_eff         (n_eff),
        .item          (item),
        .cmd           (cmd),
        .stat          (stat),
        .code_out      (out_ch.code_out),
        .lookup_failed (out_ch.lookup_failed),
        .out_valid     (out_ch.valid),
        .out_ready     (out_ch.ready)
    );

endmodule

>>> rtl/rce_checker.sv
module rce_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [2:0]  in_op,
    input logic        out_valid,
    input logic        out_ready,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic        pready,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);

    // A pending result stays offered until taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");

    // One item at a time: the engine is busy right after taking one.
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while busy");

    // Only an encode item may start a result.
    a_no_result_for_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_op != rce_pkg::OP_ENCODE |=> !$rose(out_valid))
        else $error("result raised for a non-encode item");

    // rotor_count reads back what was written.
    a_rcount_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && paddr[2]
        |=> !paddr[2] || prdata == {28'd0, $past(pwdata[3:0])})
        else $error("rotor_count readback mismatch");

endmodule

bind rotor_cipher_byte_engine rce_checker u_rce_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_op     (in_ch.op),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);
